// ===== src/tah_pkg.sv =====
// Shared types and constants for the threshold alarm with hold time.
// Holds the condition state encoding, reason codes and register indexes.
// No dependencies.
package tah_pkg;

    // fixed field widths
    localparam int QUAL_W      = 2;
    localparam int HOLD_W      = 32;
    localparam int COND_W      = 2;
    localparam int REASON_W    = 3;
    localparam int CFG_INDEX_W = 3;

    // alarm condition, one-hot
    typedef enum logic [2:0] {
        ST_NORMAL  = 3'b001,
        ST_ACTIVE  = 3'b010,
        ST_UNKNOWN = 3'b100
    } t_cond;

    // condition codes as they appear on the result
    typedef enum logic [COND_W-1:0] {
        COND_NORMAL  = 2'd0,
        COND_ACTIVE  = 2'd1,
        COND_UNKNOWN = 2'd2
    } t_cond_code;

    // transition reasons
    typedef enum logic [REASON_W-1:0] {
        RSN_QUALITY   = 3'd0,
        RSN_NONNUM    = 3'd1,
        RSN_RECOVERED = 3'd2,
        RSN_CONFIRMED = 3'd3,
        RSN_SUSTAINED = 3'd4
    } t_reason;

    // register indexes on the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_RULE_ENABLED   = 3'd0,
        REG_LOW_DIRECTION  = 3'd1,
        REG_TRIGGER_LEVEL  = 3'd2,
        REG_RECOVERY_LEVEL = 3'd3,
        REG_HOLD_TIME_MS   = 3'd4,
        REG_MIN_QUALITY    = 3'd5
    } t_cfg_index;

    // narrow configuration fields handed to the evaluation stage
    typedef struct packed {
        logic              rule_enabled;
        logic              low_direction;
        logic [QUAL_W-1:0] min_quality;
        logic [HOLD_W-1:0] hold_time_ms;
    } t_cfg;

    // decision of the evaluation stage
    typedef struct packed {
        logic       emit;
        t_cond_code cond;
        t_reason    reason;
    } t_result;

endpackage

// ===== src/tah_cfg_regs.sv =====
// Configuration register file for the threshold alarm.
// Depends on tah_pkg; flags a state clear on every write to a listed register.
module tah_cfg_regs
    import tah_pkg::*;
#(
    parameter int VALUE_WIDTH = 32,
    parameter int DATA_WIDTH  = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr,
    input  logic [CFG_INDEX_W-1:0]        i_index,
    input  logic [DATA_WIDTH-1:0]         i_data,
    output t_cfg                          o_cfg,
    output logic signed [VALUE_WIDTH-1:0] o_trigger,
    output logic signed [VALUE_WIDTH-1:0] o_recovery,
    output logic                          o_clear
);

    logic                   r_rule_enabled;
    logic                   r_low_direction;
    logic [VALUE_WIDTH-1:0] r_trigger;
    logic [VALUE_WIDTH-1:0] r_recovery;
    logic [HOLD_W-1:0]      r_hold;
    logic [QUAL_W-1:0]      r_min_quality;
    logic                   w_known;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rule_enabled  <= 1'b1;
            r_low_direction <= 1'b0;
            r_trigger       <= '0;
            r_recovery      <= '0;
            r_hold          <= '0;
            r_min_quality   <= QUAL_W'(3);
        end else if (i_wr) begin
            unique case (i_index)
                REG_RULE_ENABLED:   r_rule_enabled  <= i_data[0];
                REG_LOW_DIRECTION:  r_low_direction <= i_data[0];
                REG_TRIGGER_LEVEL:  r_trigger       <= i_data[VALUE_WIDTH-1:0];
                REG_RECOVERY_LEVEL: r_recovery      <= i_data[VALUE_WIDTH-1:0];
                REG_HOLD_TIME_MS:   r_hold          <= i_data[HOLD_W-1:0];
                REG_MIN_QUALITY:    r_min_quality   <= i_data[QUAL_W-1:0];
                default: ;
            endcase
        end
    end

    // writes past the register list leave the state alone
    always_comb begin
        unique case (i_index)
            REG_RULE_ENABLED, REG_LOW_DIRECTION, REG_TRIGGER_LEVEL,
            REG_RECOVERY_LEVEL, REG_HOLD_TIME_MS, REG_MIN_QUALITY: w_known = 1'b1;
            default: w_known = 1'b0;
        endcase
    end

    assign o_clear    = i_wr && w_known;
    assign o_cfg      = '{rule_enabled:  r_rule_enabled,
                          low_direction: r_low_direction,
                          min_quality:   r_min_quality,
                          hold_time_ms:  r_hold};
    assign o_trigger  = r_trigger;
    assign o_recovery = r_recovery;

endmodule

// ===== src/tah_eval.sv =====
// Alarm evaluation: quality gate, hysteresis compare, hold timer and state.
// Depends on tah_pkg; holds condition and pending-trigger registers.
module tah_eval
    import tah_pkg::*;
#(
    parameter int VALUE_WIDTH = 32,
    parameter int TIME_WIDTH  = 63
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic                          i_clear,
    input  t_cfg                          i_cfg,
    input  logic signed [VALUE_WIDTH-1:0] i_trigger,
    input  logic signed [VALUE_WIDTH-1:0] i_recovery,
    input  logic [QUAL_W-1:0]             i_quality,
    input  logic                          i_value_ok,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    input  logic [TIME_WIDTH-1:0]         i_sample_time,
    input  logic [TIME_WIDTH-1:0]         i_eval_time,
    output t_result                       o_result,
    output logic [TIME_WIDTH-1:0]         o_ts
);

    localparam int CMP_W = (TIME_WIDTH > HOLD_W) ? TIME_WIDTH : HOLD_W;

    t_cond                  r_cond, n_cond;
    logic                   r_pend_valid, n_pend_valid;
    logic [TIME_WIDTH-1:0]  r_pend_start, n_pend_start;

    logic                   w_gate_fail;
    logic                   w_trig;
    logic                   w_rec;
    logic [TIME_WIDTH-1:0]  w_ts;
    logic [TIME_WIDTH-1:0]  w_start;
    logic [TIME_WIDTH-1:0]  w_diff;
    logic                   w_elapsed;
    t_result                w_res;

    // resolved timestamp and threshold compares
    assign w_ts        = (i_sample_time != '0) ? i_sample_time : i_eval_time;
    assign w_gate_fail = (i_quality < i_cfg.min_quality) || !i_value_ok;
    assign w_trig      = i_cfg.low_direction ? (i_value < i_trigger) : (i_value > i_trigger);
    assign w_rec       = i_cfg.low_direction ? (i_value > i_recovery) : (i_value < i_recovery);

    // hold timer: time going backward counts as not yet elapsed
    assign w_start   = r_pend_valid ? r_pend_start : w_ts;
    assign w_diff    = w_ts - w_start;
    assign w_elapsed = (i_cfg.hold_time_ms == '0) ||
                       ((w_ts >= w_start) &&
                        (CMP_W'(w_diff) >= CMP_W'(i_cfg.hold_time_ms)));

    // next state and transition
    always_comb begin
        n_cond       = r_cond;
        n_pend_valid = r_pend_valid;
        n_pend_start = r_pend_start;
        w_res        = '{emit: 1'b0, cond: COND_NORMAL, reason: RSN_QUALITY};
        priority if (i_clear || (i_fire && !i_cfg.rule_enabled)) begin
            n_cond       = ST_NORMAL;
            n_pend_valid = 1'b0;
        end else if (i_fire && w_gate_fail) begin
            n_pend_valid = 1'b0;
            if (r_cond == ST_ACTIVE) begin
                n_cond = ST_UNKNOWN;
                w_res  = '{emit: 1'b1, cond: COND_UNKNOWN,
                           reason: (i_quality < i_cfg.min_quality) ? RSN_QUALITY : RSN_NONNUM};
            end
        end else if (i_fire && r_cond != ST_NORMAL) begin
            if (w_rec) begin
                n_cond       = ST_NORMAL;
                n_pend_valid = 1'b0;
                w_res        = '{emit: 1'b1, cond: COND_NORMAL, reason: RSN_RECOVERED};
            end else if (r_cond == ST_UNKNOWN) begin
                n_cond = ST_ACTIVE;
                w_res  = '{emit: 1'b1, cond: COND_ACTIVE, reason: RSN_CONFIRMED};
            end
        end else if (i_fire) begin
            if (!w_trig) begin
                n_pend_valid = 1'b0;
            end else if (w_elapsed) begin
                n_cond       = ST_ACTIVE;
                n_pend_valid = 1'b0;
                w_res        = '{emit: 1'b1, cond: COND_ACTIVE, reason: RSN_SUSTAINED};
            end else if (!r_pend_valid) begin
                n_pend_valid = 1'b1;
                n_pend_start = w_ts;
            end
        end else begin
            // no sample evaluated: state holds
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cond       <= ST_NORMAL;
            r_pend_valid <= 1'b0;
        end else begin
            r_cond       <= n_cond;
            r_pend_valid <= n_pend_valid;
        end
    end

    // pending start is qualified by its valid bit
    always_ff @(posedge i_clk) begin
        r_pend_start <= n_pend_start;
    end

    assign o_result = w_res;
    assign o_ts     = w_ts;

endmodule

// ===== src/threshold_alarm_with_hold_time_unit.sv =====
// Top level of the threshold alarm with hysteresis, quality gate and hold time.
// Depends on tah_pkg, tah_cfg_regs and tah_eval.
//
// Tracks the alarm condition (normal, active, unknown) of one measured point.
// One sample is taken per clock cycle while the master side takes results;
// each sample passes through an input register, one evaluation stage that
// reads and updates the condition and hold-timer state in the same cycle, and
// a result register, which offers the transition on the master side. A sample
// that causes no transition produces no output transaction. Throughput is one
// sample per cycle while the master side takes results; a stalled result holds
// the evaluation stage and the input register then fills and drops tready.
// Configuration writes to a listed register return the alarm state to normal and must be issued
// only while no sample is in flight.
module threshold_alarm_with_hold_time_unit
    import tah_pkg::*;
#(
    parameter int VALUE_WIDTH = 32,
    parameter int TIME_WIDTH  = 63
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // sample stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // sample_value, sample_time, eval_time, zero fill
    input  logic [((VALUE_WIDTH+2*TIME_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // sample_quality, value_ok
    input  logic [QUAL_W:0]        s_axis_tuser,
    // transition stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // new_condition, event_time, zero fill
    output logic [((COND_W+TIME_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // reason_code
    output logic [REASON_W-1:0]    m_axis_tuser,
    // configuration writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [((VALUE_WIDTH > HOLD_W) ? VALUE_WIDTH : HOLD_W)-1:0] i_cfg_data
);

    localparam int DATA_WIDTH = (VALUE_WIDTH > HOLD_W) ? VALUE_WIDTH : HOLD_W;
    localparam int IN_W       = ((VALUE_WIDTH + 2*TIME_WIDTH + 7) / 8) * 8;
    localparam int OUT_W      = ((COND_W + TIME_WIDTH + 7) / 8) * 8;
    localparam int ST_LO      = VALUE_WIDTH;
    localparam int ET_LO      = VALUE_WIDTH + TIME_WIDTH;

    t_cfg                          w_cfg;
    logic signed [VALUE_WIDTH-1:0] w_trigger;
    logic signed [VALUE_WIDTH-1:0] w_recovery;
    logic                          w_clear;
    logic                          w_fire;
    t_result                       w_res;
    logic [TIME_WIDTH-1:0]         w_ts;

    logic                          r_in_valid;
    logic [QUAL_W-1:0]             r_quality;
    logic                          r_value_ok;
    logic signed [VALUE_WIDTH-1:0] r_value;
    logic [TIME_WIDTH-1:0]         r_sample_time;
    logic [TIME_WIDTH-1:0]         r_eval_time;

    logic                          r_out_valid, n_out_valid;
    t_cond_code                    r_out_cond;
    t_reason                       r_out_reason;
    logic [TIME_WIDTH-1:0]         r_out_time;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    tah_cfg_regs #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (i_cfg_valid && o_cfg_ready),
        .i_index    (i_cfg_index),
        .i_data     (i_cfg_data),
        .o_cfg      (w_cfg),
        .o_trigger  (w_trigger),
        .o_recovery (w_recovery),
        .o_clear    (w_clear)
    );

    // the held sample is evaluated once the result register can take its outcome
    assign w_fire        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_fire;

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_quality     <= s_axis_tuser[QUAL_W-1:0];
            r_value_ok    <= s_axis_tuser[QUAL_W];
            r_value       <= s_axis_tdata[VALUE_WIDTH-1:0];
            r_sample_time <= s_axis_tdata[ST_LO +: TIME_WIDTH];
            r_eval_time   <= s_axis_tdata[ET_LO +: TIME_WIDTH];
        end
    end

    // evaluation stage
    tah_eval #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_eval (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (w_fire),
        .i_clear       (w_clear),
        .i_cfg         (w_cfg),
        .i_trigger     (w_trigger),
        .i_recovery    (w_recovery),
        .i_quality     (r_quality),
        .i_value_ok    (r_value_ok),
        .i_value       (r_value),
        .i_sample_time (r_sample_time),
        .i_eval_time   (r_eval_time),
        .o_result      (w_res),
        .o_ts          (w_ts)
    );

    // result register control
    always_comb begin
        n_out_valid = r_out_valid;
        priority if (w_fire) begin
            n_out_valid = w_res.emit;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (w_fire && w_res.emit) begin
            r_out_cond   <= w_res.cond;
            r_out_reason <= w_res.reason;
            r_out_time   <= w_ts;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'({r_out_time, r_out_cond});
    assign m_axis_tuser  = r_out_reason;

endmodule

// ===== src/tah_checker.sv =====
// Port-level checks for the threshold alarm unit, attached by bind.
// Depends on tah_pkg and threshold_alarm_with_hold_time_unit.
module tah_checker
    import tah_pkg::*;
#(
    parameter int TIME_WIDTH = 63
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [((COND_W+TIME_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    input logic [REASON_W-1:0]    m_axis_tuser
);

    // a stalled result transaction keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // reason code agrees with the condition entered
    a_reason_cond: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (((m_axis_tuser == RSN_QUALITY) || (m_axis_tuser == RSN_NONNUM)) &&
                (m_axis_tdata[COND_W-1:0] == COND_UNKNOWN)) ||
            ((m_axis_tuser == RSN_RECOVERED) &&
                (m_axis_tdata[COND_W-1:0] == COND_NORMAL)) ||
            (((m_axis_tuser == RSN_CONFIRMED) || (m_axis_tuser == RSN_SUSTAINED)) &&
                (m_axis_tdata[COND_W-1:0] == COND_ACTIVE)))
        else $error("reason code does not match condition");

    // reset empties the result register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // reset empties the input register
    a_reset_in: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("sample side not ready after reset");

endmodule

bind threshold_alarm_with_hold_time_unit tah_checker #(
    .TIME_WIDTH (TIME_WIDTH)
) u_tah_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/tb_threshold_alarm_with_hold_time_unit.sv =====
// Self-checking bench for threshold_alarm_with_hold_time_unit: a directed table and
// randomized sample runs under several register settings, checked against a local predictor.
// Depends on tah_pkg and the threshold_alarm_with_hold_time_unit RTL.
module tb_threshold_alarm_with_hold_time_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import tah_pkg::*;

    localparam int VALUE_W  = 32;
    localparam int TIME_W   = 63;
    localparam int S_DATA_W = ((VALUE_W + 2 * TIME_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((COND_W + TIME_W + 7) / 8) * 8;

    localparam int RESET_CYCLES   = 5;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_STALL     = 300;
    localparam int N_PHASES       = 12;
    localparam int PHASE_ITEMS    = 165;
    localparam int DISABLED_ITEMS = 40;
    localparam int DISABLED_PHASE = 3;
    localparam int PRESSURE_PHASE = 8;

    // quality ranks
    localparam logic [1:0] Q_BAD       = 2'd0;
    localparam logic [1:0] Q_STALE     = 2'd1;
    localparam logic [1:0] Q_UNCERTAIN = 2'd2;
    localparam logic [1:0] Q_GOOD      = 2'd3;

    // register indexes past the end of the register list
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_7 = 3'd7;

    localparam logic [31:0]       V_MAX  = 32'h7fff_ffff;
    localparam logic [31:0]       V_MIN  = 32'h8000_0000;
    localparam logic [31:0]       ONE_Q  = 32'h0001_0000;
    localparam logic [TIME_W-1:0] MAX_MS = {TIME_W{1'b1}};

    typedef struct packed {
        logic [1:0]         quality;
        logic               value_ok;
        logic [VALUE_W-1:0] value;
        logic [TIME_W-1:0]  sample_ms;
        logic [TIME_W-1:0]  eval_ms;
    } t_sample;

    typedef struct packed {
        t_cond_code        cond;
        t_reason           reason;
        logic [TIME_W-1:0] at_ms;
    } t_transition;

    typedef enum {ROW_WRITE, ROW_SAMPLE} t_row_kind;
    typedef enum {CHK_MODEL, CHK_QUIET, CHK_EVENT} t_row_check;

    typedef struct {
        t_row_kind              kind;
        logic [CFG_INDEX_W-1:0] reg_idx;
        logic [31:0]            reg_data;
        t_sample                smp;
        t_row_check             check;
        t_cond_code             cond;
        t_reason                reason;
    } t_stim_row;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_DATA_W-1:0]    s_axis_tdata  = '0;
    logic [QUAL_W:0]        s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]    m_axis_tdata;
    logic [REASON_W-1:0]    m_axis_tuser;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index   = '0;
    logic [31:0]            i_cfg_data    = '0;

    // predictor copy of the registers and the alarm state
    logic              cfg_enabled     = 1'b1;
    logic              cfg_low_dir     = 1'b0;
    logic [31:0]       cfg_trigger     = '0;
    logic [31:0]       cfg_recovery    = '0;
    logic [31:0]       cfg_hold        = '0;
    logic [1:0]        cfg_min_quality = Q_GOOD;
    t_cond_code        alarm_cond      = COND_NORMAL;
    logic              hold_pending    = 1'b0;
    logic [TIME_W-1:0] hold_start      = '0;

    t_transition transition_fifo[$];
    t_stim_row   stim_rows[$];

    int tx_idle_pct      = 18;
    int rx_idle_pct      = 67;
    int stall_left       = 0;
    logic long_stall_req  = 1'b0;
    logic long_stall_done = 1'b0;
    int idle_cycles      = 0;
    int mismatch_count   = 0;
    int samples_sent     = 0;
    int transitions_seen = 0;
    int register_writes  = 0;

    threshold_alarm_with_hold_time_unit #(
        .VALUE_WIDTH (VALUE_W),
        .TIME_WIDTH  (TIME_W)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void drop_alarm_state();
        alarm_cond   = COND_NORMAL;
        hold_pending = 1'b0;
        hold_start   = '0;
    endfunction

    // append one stimulus row to the directed table
    function automatic void queue_row(input t_stim_row row);
        stim_rows.insert(stim_rows.size(), row);
    endfunction

    // append one predicted transition to the scoreboard queue
    function automatic void queue_transition(input t_transition t);
        transition_fifo.insert(transition_fifo.size(), t);
    endfunction

    // next alarm transition caused by one sample, updating the predicted state
    function automatic bit compute_transition(input t_sample s, output t_transition t);
        logic [TIME_W-1:0] ts;
        logic              trig_hit;
        logic              rec_hit;
        ts       = (s.sample_ms != '0) ? s.sample_ms : s.eval_ms;
        t.cond   = COND_NORMAL;
        t.reason = RSN_QUALITY;
        t.at_ms  = ts;
        if (!cfg_enabled) begin
            drop_alarm_state();
            return 1'b0;
        end
        // gated out or non-numeric: the pending trigger goes, active turns unknown
        if (s.quality < cfg_min_quality || !s.value_ok) begin
            hold_pending = 1'b0;
            hold_start   = '0;
            if (alarm_cond == COND_ACTIVE) begin
                alarm_cond = COND_UNKNOWN;
                t.cond     = COND_UNKNOWN;
                t.reason   = (s.quality < cfg_min_quality) ? RSN_QUALITY : RSN_NONNUM;
                return 1'b1;
            end
            return 1'b0;
        end
        if (cfg_low_dir) begin
            trig_hit = $signed(s.value) < $signed(cfg_trigger);
            rec_hit  = $signed(s.value) > $signed(cfg_recovery);
        end else begin
            trig_hit = $signed(s.value) > $signed(cfg_trigger);
            rec_hit  = $signed(s.value) < $signed(cfg_recovery);
        end
        // active or unknown: recovery, or unknown confirmed back to active
        if (alarm_cond != COND_NORMAL) begin
            if (rec_hit) begin
                drop_alarm_state();
                t.reason = RSN_RECOVERED;
                return 1'b1;
            end
            if (alarm_cond == COND_UNKNOWN) begin
                alarm_cond = COND_ACTIVE;
                t.cond     = COND_ACTIVE;
                t.reason   = RSN_CONFIRMED;
                return 1'b1;
            end
            return 1'b0;
        end
        if (!trig_hit) begin
            hold_pending = 1'b0;
            hold_start   = '0;
            return 1'b0;
        end
        // normal: trigger must persist for the hold time
        if (!hold_pending) begin
            hold_pending = 1'b1;
            hold_start   = ts;
        end
        if (cfg_hold == '0 ||
            (ts >= hold_start && (ts - hold_start) >= {{(TIME_W-32){1'b0}}, cfg_hold})) begin
            drop_alarm_state();
            alarm_cond = COND_ACTIVE;
            t.cond     = COND_ACTIVE;
            t.reason   = RSN_SUSTAINED;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [TIME_W-1:0] rand_ms();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[TIME_W-1:0];
    endfunction

    // a value a few counts around a level
    function automatic logic [31:0] level_nudge(input logic [31:0] lvl);
        return lvl + 32'($urandom_range(0, 6)) - 32'd3;
    endfunction

    function automatic t_stim_row write_row(input logic [CFG_INDEX_W-1:0] idx,
                                            input logic [31:0] data);
        t_stim_row row;
        row.kind     = ROW_WRITE;
        row.reg_idx  = idx;
        row.reg_data = data;
        row.smp      = '0;
        row.check    = CHK_QUIET;
        row.cond     = COND_NORMAL;
        row.reason   = RSN_QUALITY;
        return row;
    endfunction

    function automatic t_stim_row sample_row(input logic [1:0] q, input logic ok,
                                             input logic [31:0] v, input logic [TIME_W-1:0] st,
                                             input logic [TIME_W-1:0] et, input t_row_check chk);
        t_stim_row row;
        row        = write_row('0, '0);
        row.kind   = ROW_SAMPLE;
        row.smp    = '{quality: q, value_ok: ok, value: v, sample_ms: st, eval_ms: et};
        row.check  = chk;
        return row;
    endfunction

    function automatic t_stim_row event_row(input logic [1:0] q, input logic ok,
                                            input logic [31:0] v, input logic [TIME_W-1:0] st,
                                            input logic [TIME_W-1:0] et, input t_cond_code c,
                                            input t_reason rsn);
        t_stim_row row;
        row        = sample_row(q, ok, v, st, et, CHK_EVENT);
        row.cond   = c;
        row.reason = rsn;
        return row;
    endfunction

    // register write once the block has gone quiet; updates the predictor copy
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        logic known;
        s_axis_tvalid <= 1'b0;
        while (transition_fifo.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        register_writes++;
        known = 1'b1;
        case (idx)
            REG_RULE_ENABLED:   cfg_enabled     = data[0];
            REG_LOW_DIRECTION:  cfg_low_dir     = data[0];
            REG_TRIGGER_LEVEL:  cfg_trigger     = data;
            REG_RECOVERY_LEVEL: cfg_recovery    = data;
            REG_HOLD_TIME_MS:   cfg_hold        = data;
            REG_MIN_QUALITY:    cfg_min_quality = data[1:0];
            default:            known           = 1'b0;
        endcase
        if (known) drop_alarm_state();
    endtask

    // offer one sample and return at the edge where it is accepted
    task automatic send_sample(input t_sample s);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, s.eval_ms, s.sample_ms, s.value};
        s_axis_tuser  <= {s.value_ok, s.quality};
        do @(posedge i_clk); while (!s_axis_tready);
        samples_sent++;
    endtask

    // result side readiness, with one long hold-off on request
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (long_stall_req && !long_stall_done) begin
            m_axis_tready   <= 1'b0;
            stall_left      <= LONG_STALL;
            long_stall_done <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // compare each result transaction with the oldest predicted transition
    always @(posedge i_clk) begin
        t_transition want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (transition_fifo.size() == 0) begin
                $error("transition with none expected: condition %0d reason %0d time %0d",
                       m_axis_tdata[1:0], m_axis_tuser, m_axis_tdata[TIME_W+1:2]);
                mismatch_count++;
            end else begin
                want = transition_fifo.pop_front();
                transitions_seen++;
                if (m_axis_tdata[1:0] !== want.cond) begin
                    $error("new_condition: expected %0d, actual %0d", want.cond,
                           m_axis_tdata[1:0]);
                    mismatch_count++;
                end
                if (m_axis_tuser !== want.reason) begin
                    $error("reason_code: expected %0d, actual %0d", want.reason, m_axis_tuser);
                    mismatch_count++;
                end
                if (m_axis_tdata[TIME_W+1:2] !== want.at_ms) begin
                    $error("event_time: expected %0d, actual %0d", want.at_ms,
                           m_axis_tdata[TIME_W+1:2]);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", idle_cycles);
            $display("tb_threshold_alarm_with_hold_time_unit NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_sample           smp;
        t_transition       tr;
        logic [TIME_W-1:0] clock_ms;
        logic [TIME_W-1:0] step;
        logic [31:0]       trig;
        logic [31:0]       rec;
        logic [31:0]       hold;
        logic [1:0]        minq;
        logic              low;
        logic              en;
        bit                hit;
        int                n_items;
        int                r;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, starting from reset settings: above, levels 0, no hold, good only
        queue_row(event_row(Q_GOOD, 1'b1, 32'h1, 63'd5, 63'd0, COND_ACTIVE, RSN_SUSTAINED));
        queue_row(sample_row(Q_GOOD, 1'b1, V_MAX, 63'd0, 63'd10, CHK_QUIET));
        queue_row(event_row(Q_UNCERTAIN, 1'b1, 32'h0, 63'd0, MAX_MS,
                            COND_UNKNOWN, RSN_QUALITY));
        queue_row(event_row(Q_GOOD, 1'b1, 32'h1, 63'd7, 63'd0, COND_ACTIVE, RSN_CONFIRMED));
        queue_row(event_row(Q_GOOD, 1'b0, 32'h1, 63'd8, 63'd0, COND_UNKNOWN, RSN_NONNUM));
        queue_row(event_row(Q_GOOD, 1'b1, 32'hffff_ffff, 63'd9, 63'd0,
                            COND_NORMAL, RSN_RECOVERED));
        queue_row(sample_row(Q_BAD, 1'b0, V_MIN, MAX_MS, MAX_MS, CHK_QUIET));
        // hold time with a pending start at time zero, then time going backward
        queue_row(write_row(REG_HOLD_TIME_MS, 32'd100));
        queue_row(write_row(REG_TRIGGER_LEVEL, ONE_Q));
        queue_row(sample_row(Q_GOOD, 1'b1, 2 * ONE_Q, 63'd0, 63'd0, CHK_QUIET));
        queue_row(sample_row(Q_GOOD, 1'b1, 2 * ONE_Q, 63'd50, 63'd0, CHK_MODEL));
        queue_row(event_row(Q_GOOD, 1'b1, 2 * ONE_Q, 63'd100, 63'd0,
                            COND_ACTIVE, RSN_SUSTAINED));
        queue_row(sample_row(Q_GOOD, 1'b1, ONE_Q, 63'd0, 63'd0, CHK_QUIET));
        queue_row(event_row(Q_GOOD, 1'b1, V_MIN, 63'd201, 63'd0,
                            COND_NORMAL, RSN_RECOVERED));
        queue_row(sample_row(Q_GOOD, 1'b1, 2 * ONE_Q, 63'd1000, 63'd0, CHK_QUIET));
        queue_row(sample_row(Q_GOOD, 1'b1, 2 * ONE_Q, 63'd500, 63'd0, CHK_MODEL));
        queue_row(sample_row(Q_GOOD, 1'b1, 2 * ONE_Q, 63'd1099, 63'd0, CHK_MODEL));
        queue_row(sample_row(Q_GOOD, 1'b1, ONE_Q, 63'd1100, 63'd0, CHK_MODEL));
        queue_row(sample_row(Q_GOOD, 1'b1, 2 * ONE_Q, 63'd1150, 63'd0, CHK_MODEL));
        queue_row(sample_row(Q_UNCERTAIN, 1'b1, 2 * ONE_Q, 63'd1250, 63'd0, CHK_MODEL));
        queue_row(sample_row(Q_GOOD, 1'b1, 2 * ONE_Q, 63'd1260, 63'd0, CHK_MODEL));
        queue_row(sample_row(Q_GOOD, 1'b1, 2 * ONE_Q, 63'd1359, 63'd0, CHK_MODEL));
        queue_row(event_row(Q_GOOD, 1'b1, 2 * ONE_Q, 63'd1360, 63'd0,
                            COND_ACTIVE, RSN_SUSTAINED));
        // a write past the register list leaves the active alarm alone
        queue_row(write_row(REG_SPARE_6, 32'hffff_ffff));
        queue_row(event_row(Q_GOOD, 1'b0, 32'h0, 63'd1400, 63'd0,
                            COND_UNKNOWN, RSN_NONNUM));
        // below direction with negative trigger
        queue_row(write_row(REG_LOW_DIRECTION, 32'd1));
        queue_row(write_row(REG_TRIGGER_LEVEL, 32'hffff_0000));
        queue_row(write_row(REG_RECOVERY_LEVEL, ONE_Q));
        queue_row(write_row(REG_HOLD_TIME_MS, 32'd0));
        queue_row(event_row(Q_GOOD, 1'b1, V_MIN, 63'd5, 63'd0, COND_ACTIVE, RSN_SUSTAINED));
        queue_row(sample_row(Q_GOOD, 1'b1, ONE_Q, 63'd6, 63'd0, CHK_QUIET));
        queue_row(event_row(Q_GOOD, 1'b1, V_MAX, 63'd7, 63'd0, COND_NORMAL, RSN_RECOVERED));
        queue_row(write_row(REG_MIN_QUALITY, {30'd0, Q_BAD}));
        queue_row(event_row(Q_BAD, 1'b1, V_MIN, 63'd8, 63'd0, COND_ACTIVE, RSN_SUSTAINED));
        queue_row(write_row(REG_RULE_ENABLED, 32'd0));
        queue_row(sample_row(Q_STALE, 1'b1, V_MIN, 63'd9, 63'd0, CHK_QUIET));
        queue_row(write_row(REG_RULE_ENABLED, 32'd1));
        queue_row(sample_row(Q_GOOD, 1'b1, V_MIN, 63'd10, 63'd0, CHK_MODEL));

        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_WRITE) begin
                write_register(stim_rows[i].reg_idx, stim_rows[i].reg_data);
            end else begin
                send_sample(stim_rows[i].smp);
                hit = compute_transition(stim_rows[i].smp, tr);
                case (stim_rows[i].check)
                    CHK_MODEL: if (hit) queue_transition(tr);
                    CHK_EVENT: begin
                        tr.cond   = stim_rows[i].cond;
                        tr.reason = stim_rows[i].reason;
                        queue_transition(tr);
                    end
                    default: ;
                endcase
            end
        end

        // random phases, each under its own register setting
        for (int p = 0; p < N_PHASES; p++) begin
            if (p < 4) begin
                tx_idle_pct = 18;
                rx_idle_pct <= 67;
            end else if (p < 8) begin
                tx_idle_pct = 67;
                rx_idle_pct <= 18;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
            end

            en   = (p != DISABLED_PHASE);
            low  = 1'($urandom_range(1));
            r    = $urandom_range(99);
            trig = (r < 15) ? V_MAX : (r < 30) ? V_MIN : $urandom;
            r    = $urandom_range(99);
            if (r < 50)
                rec = low ? trig + 32'($urandom_range(0, 1000))
                          : trig - 32'($urandom_range(0, 1000));
            else if (r < 70)
                rec = trig;
            else if (r < 80)
                rec = low ? V_MAX : V_MIN;
            else
                rec = $urandom;
            r    = $urandom_range(99);
            hold = (r < 25) ? 32'd0 : (r < 70) ? 32'($urandom_range(1, 40)) :
                   (r < 85) ? 32'hffff_ffff : $urandom;
            minq = 2'($urandom_range(0, 3));
            // fixed extreme settings and a chatty one for the long hold-off
            if (p == 0) begin
                low  = 1'b0;
                trig = V_MIN;
                rec  = V_MAX;
                hold = 32'hffff_ffff;
                minq = Q_BAD;
            end else if (p == 1) begin
                low  = 1'b1;
                trig = V_MAX;
                rec  = V_MIN;
                hold = 32'd0;
                minq = Q_GOOD;
            end else if (p == PRESSURE_PHASE) begin
                low  = 1'b0;
                trig = 32'd0;
                rec  = 32'd0;
                hold = 32'd0;
                minq = Q_BAD;
            end
            write_register(REG_RULE_ENABLED, {31'd0, en});
            write_register(REG_LOW_DIRECTION, {31'd0, low});
            write_register(REG_TRIGGER_LEVEL, trig);
            write_register(REG_RECOVERY_LEVEL, rec);
            write_register(REG_HOLD_TIME_MS, hold);
            write_register(REG_MIN_QUALITY, {30'd0, minq});
            if (p == 2) write_register(REG_SPARE_7, $urandom);
            if (p == PRESSURE_PHASE) long_stall_req <= 1'b1;

            r = $urandom_range(99);
            clock_ms = (r < 50) ? TIME_W'($urandom_range(0, 1000)) :
                       (r < 75) ? rand_ms() : MAX_MS - TIME_W'($urandom_range(0, 1 << 20));
            n_items = (p == DISABLED_PHASE) ? DISABLED_ITEMS : PHASE_ITEMS;

            for (int k = 0; k < n_items; k++) begin
                // advance the time base, now and then by a whole hold time
                r = $urandom_range(99);
                step = (r < 10) ? {{(TIME_W-32){1'b0}}, cfg_hold} :
                       (r < 15) ? '0 : TIME_W'($urandom_range(0, 8));
                if (clock_ms > MAX_MS - step)
                    clock_ms = TIME_W'($urandom_range(0, 1000));
                else
                    clock_ms = clock_ms + step;

                r = $urandom_range(99);
                smp.quality  = (r < 85) ? 2'($urandom_range(cfg_min_quality, 3))
                                        : 2'($urandom_range(0, 3));
                smp.value_ok = ($urandom_range(99) < 95);
                r = $urandom_range(99);
                smp.value = (r < 35) ? level_nudge(cfg_trigger) :
                            (r < 70) ? level_nudge(cfg_recovery) :
                            (r < 75) ? V_MIN : (r < 80) ? V_MAX : $urandom;
                r = $urandom_range(99);
                if (r < 85) begin
                    smp.sample_ms = clock_ms;
                    smp.eval_ms   = rand_ms();
                end else if (r < 95) begin
                    smp.sample_ms = '0;
                    smp.eval_ms   = clock_ms;
                end else begin
                    smp.sample_ms = rand_ms();
                    smp.eval_ms   = rand_ms();
                end

                send_sample(smp);
                if (compute_transition(smp, tr)) queue_transition(tr);
            end
        end

        // drain, then allow the pipeline to settle
        s_axis_tvalid <= 1'b0;
        while (transition_fifo.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES * 4) @(posedge i_clk);

        $display("run covered %0d samples and %0d alarm transitions", samples_sent,
                 transitions_seen);
        $display("across %0d register writes over %0d random settings plus directed cases",
                 register_writes, N_PHASES);
        if (mismatch_count == 0) begin
            $display("tb_threshold_alarm_with_hold_time_unit OK");
        end else begin
            $display("tb_threshold_alarm_with_hold_time_unit NOT OK");
        end
        $finish;
    end

endmodule
